>>> hw/rtl/hvt_pkg.sv
// Shared types, constants and helpers for the homogeneous vertex transform.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none
package hvt_pkg;

  localparam int COORD_W   = 16;
  localparam int FRAC_BITS = 8;
  localparam int COEF_W    = 16;
  localparam int PROD_W    = COORD_W + COEF_W;        // one vertex x coefficient
  localparam int SUM_W     = PROD_W + 2;              // four products
  localparam int MAG_W     = SUM_W - 1;               // magnitude of a sum
  localparam int SHF_W     = SUM_W - FRAC_BITS;       // sum >>> FRAC_BITS
  localparam int DSH_W     = MAG_W + COORD_W - 1;     // divisor moved to top quotient bit
  localparam int SCR_W     = PROD_W - FRAC_BITS + 2;  // screen sums before clipping
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;
  localparam int MAT_W     = 4 * COEF_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAT_X    = 3'd0,
    CFG_MAT_Y    = 3'd1,
    CFG_MAT_Z    = 3'd2,
    CFG_MAT_W    = 3'd3,
    CFG_DIV_EN   = 3'd4,
    CFG_OBLIQUE  = 3'd5,
    CFG_CENTER   = 3'd6
  } cfg_idx_e;

  // Payload that walks through the divider stages.
  typedef struct packed {
    logic                          do_div;
    logic [2:0]                    neg;
    logic [2:0]                    ovf;
    logic [DSH_W-1:0]              dsh;
    logic [2:0][MAG_W-1:0]         rem;
    logic [2:0][COORD_W-1:0]       quo;
    logic [3:0][SHF_W-1:0]         shf;
  } div_t;

  typedef struct packed {
    logic               sat;
    logic [COORD_W-1:0] val;
  } clip_t;

  function automatic logic [MAG_W-1:0] abs_sum(logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] n;
    n = -v;
    return v[SUM_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

  // Saturate a signed SCR_W-bit value (shorter values are sign-extended by callers).
  function automatic clip_t clip_val(logic signed [SCR_W-1:0] v);
    clip_t r;
    logic signed [SCR_W-1:0] hi;
    logic signed [SCR_W-1:0] lo;
    hi = SCR_W'((1 << (COORD_W - 1)) - 1);
    lo = -hi - SCR_W'(1);
    r.sat = 1'b0;
    r.val = v[COORD_W-1:0];
    if (v > hi) begin
      r.sat = 1'b1;
      r.val = hi[COORD_W-1:0];
    end else if (v < lo) begin
      r.sat = 1'b1;
      r.val = lo[COORD_W-1:0];
    end
    return r;
  endfunction

  // Signed quotient from magnitude, sign and overflow, saturated.
  function automatic clip_t clip_quo(logic ovf, logic neg, logic [COORD_W-1:0] q);
    clip_t r;
    logic [COORD_W:0] half;
    logic [COORD_W:0] qn;
    half = (COORD_W+1)'(1) << (COORD_W - 1);
    qn   = -{1'b0, q};
    r.sat = 1'b0;
    r.val = q;
    if (ovf) begin
      r.sat = 1'b1;
      r.val = neg ? half[COORD_W-1:0] : (half[COORD_W-1:0] - COORD_W'(1));
    end else if (!neg) begin
      if ({1'b0, q} >= half) begin
        r.sat = 1'b1;
        r.val = half[COORD_W-1:0] - COORD_W'(1);
      end
    end else begin
      if ({1'b0, q} > half) begin
        r.sat = 1'b1;
        r.val = half[COORD_W-1:0];
      end else begin
        r.val = qn[COORD_W-1:0];
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/hvt_if.sv
// Stream interfaces for vertices in and transformed vertices out.
// Depends on hvt_pkg for the coordinate width.
`timescale 1ns / 1ps
`default_nettype none
interface hvt_in_if;
  logic                          valid;
  logic                          ready;
  logic [hvt_pkg::COORD_W-1:0]   in_x;
  logic [hvt_pkg::COORD_W-1:0]   in_y;
  logic [hvt_pkg::COORD_W-1:0]   in_z;
  logic [hvt_pkg::COORD_W-1:0]   in_w;
  modport source (output valid, in_x, in_y, in_z, in_w, input ready);
  modport sink   (input valid, in_x, in_y, in_z, in_w, output ready);
endinterface

interface hvt_out_if;
  logic                          valid;
  logic                          ready;
  logic [hvt_pkg::COORD_W-1:0]   out_x;
  logic [hvt_pkg::COORD_W-1:0]   out_y;
  logic [hvt_pkg::COORD_W-1:0]   out_z;
  logic [hvt_pkg::COORD_W-1:0]   out_w;
  logic [hvt_pkg::COORD_W-1:0]   screen_x;
  logic [hvt_pkg::COORD_W-1:0]   screen_y;
  logic                          saturated;
  modport source (output valid, out_x, out_y, out_z, out_w, screen_x, screen_y, saturated,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_w, screen_x, screen_y, saturated,
                  output ready);
endinterface
`default_nettype wire

>>> hw/rtl/hvt_mac.sv
// Matrix multiply: products, column sums, then divider setup (abs, overflow, shift).
// Depends on hvt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hvt_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  logic                                 valid_i,
  input  logic [3:0][hvt_pkg::COORD_W-1:0]     vtx_i,
  input  logic [3:0][hvt_pkg::MAT_W-1:0]       mat_i,
  input  logic                                 div_en_i,
  output logic                                 valid_o,
  output hvt_pkg::div_t                        div_o
);
  import hvt_pkg::*;

  logic [PROD_W-1:0] prod_d [4][4];
  logic [PROD_W-1:0] prod_q [4][4];
  logic [SUM_W-1:0]  sum_d  [4];
  logic [SUM_W-1:0]  sum_q  [4];
  div_t              div_d;
  div_t              div_q;
  logic              va_q, vb_q, vc_q;
  logic [MAG_W-1:0]  den;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 4; k++) begin
        prod_d[j][k] = $signed(vtx_i[k]) * $signed(mat_i[j][COEF_W*k +: COEF_W]);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      sum_d[j] = '0;
      for (int k = 0; k < 4; k++) begin
        sum_d[j] = sum_d[j] + {{(SUM_W-PROD_W){prod_q[j][k][PROD_W-1]}}, prod_q[j][k]};
      end
    end
  end

  always_comb begin
    den          = abs_sum(sum_q[3]);
    div_d        = '0;
    div_d.do_div = div_en_i && (sum_q[3] != '0);
    div_d.dsh    = {den, {(COORD_W-1){1'b0}}};
    for (int j = 0; j < 3; j++) begin
      div_d.neg[j] = sum_q[j][SUM_W-1] ^ sum_q[3][SUM_W-1];
      div_d.rem[j] = abs_sum(sum_q[j]);
      // quotient would need more than COORD_W magnitude bits
      div_d.ovf[j] = {{COORD_W{1'b0}}, div_d.rem[j]} >= {den, {COORD_W{1'b0}}};
    end
    for (int j = 0; j < 4; j++) begin
      div_d.shf[j] = sum_q[j][SUM_W-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (adv_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= prod_d;
      sum_q  <= sum_d;
      div_q  <= div_d;
    end
  end

  assign valid_o = vc_q;
  assign div_o   = div_q;

endmodule
`default_nettype wire

>>> hw/rtl/hvt_div_stage.sv
// One restoring-division step: one quotient bit for each of x, y and z.
// Depends on hvt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hvt_div_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           valid_i,
  input  hvt_pkg::div_t  div_i,
  output logic           valid_o,
  output hvt_pkg::div_t  div_o
);
  import hvt_pkg::*;

  div_t div_d;
  div_t div_q;
  logic valid_q;
  logic ge;

  always_comb begin
    div_d     = div_i;
    div_d.dsh = div_i.dsh >> 1;
    ge        = 1'b0;
    for (int j = 0; j < 3; j++) begin
      ge = {{(DSH_W-MAG_W){1'b0}}, div_i.rem[j]} >= div_i.dsh;
      if (ge) begin
        div_d.rem[j] = div_i.rem[j] - div_i.dsh[MAG_W-1:0];
      end
      div_d.quo[j] = {div_i.quo[j][COORD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule
`default_nettype wire

>>> hw/rtl/hvt_proj.sv
// Result select and clip, oblique projection multiply, screen mapping and output register.
// Depends on hvt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hvt_proj (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic                              valid_i,
  input  hvt_pkg::div_t                     div_i,
  input  logic [2*hvt_pkg::COORD_W-1:0]     obl_i,
  input  logic [2*hvt_pkg::COORD_W-1:0]     ctr_i,
  output logic                              valid_o,
  output logic [3:0][hvt_pkg::COORD_W-1:0]  res_o,
  output logic [hvt_pkg::COORD_W-1:0]       screen_x_o,
  output logic [hvt_pkg::COORD_W-1:0]       screen_y_o,
  output logic                              sat_o
);
  import hvt_pkg::*;

  logic [3:0][COORD_W-1:0] r_d, r1_q, r2_q, r3_q;
  logic                    sat_d, sat1_q, sat2_q, sat3_q;
  logic                    v1_q, v2_q, v3_q;
  logic [PROD_W-1:0]       px_d, py_d, px_q, py_q;
  logic [SCR_W-1:0]        sx, sy;
  logic [COORD_W-1:0]      sx_d, sy_d, sx_q, sy_q;
  logic                    ssat_d;
  clip_t                   c;
  clip_t                   cx, cy;

  always_comb begin
    sat_d = 1'b0;
    r_d   = '0;
    c     = '0;
    for (int j = 0; j < 4; j++) begin
      if (div_i.do_div && j < 3) begin
        c = clip_quo(div_i.ovf[j], div_i.neg[j], div_i.quo[j]);
      end else if (div_i.do_div) begin
        c = '{sat: 1'b0, val: COORD_W'(1)};
      end else begin
        c = clip_val({{(SCR_W-SHF_W){div_i.shf[j][SHF_W-1]}}, div_i.shf[j]});
      end
      r_d[j] = c.val;
      sat_d  = sat_d | c.sat;
    end
  end

  // oblique factors use the clipped z
  assign px_d = $signed(r1_q[2]) * $signed(obl_i[COORD_W-1:0]);
  assign py_d = $signed(r1_q[2]) * $signed(obl_i[2*COORD_W-1:COORD_W]);

  always_comb begin
    sx = {{(SCR_W-COORD_W){ctr_i[COORD_W-1]}}, ctr_i[COORD_W-1:0]}
       + {{(SCR_W-COORD_W){r2_q[0][COORD_W-1]}}, r2_q[0]}
       + {{(SCR_W-PROD_W+FRAC_BITS){px_q[PROD_W-1]}}, px_q[PROD_W-1:FRAC_BITS]};
    sy = {{(SCR_W-COORD_W){ctr_i[2*COORD_W-1]}}, ctr_i[2*COORD_W-1:COORD_W]}
       - {{(SCR_W-COORD_W){r2_q[1][COORD_W-1]}}, r2_q[1]}
       - {{(SCR_W-PROD_W+FRAC_BITS){py_q[PROD_W-1]}}, py_q[PROD_W-1:FRAC_BITS]};
    cx     = clip_val(sx);
    cy     = clip_val(sy);
    sx_d   = cx.val;
    sy_d   = cy.val;
    ssat_d = sat2_q | cx.sat | cy.sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      r1_q   <= r_d;
      sat1_q <= sat_d;
      r2_q   <= r1_q;
      sat2_q <= sat1_q;
      px_q   <= px_d;
      py_q   <= py_d;
      r3_q   <= r2_q;
      sat3_q <= ssat_d;
      sx_q   <= sx_d;
      sy_q   <= sy_d;
    end
  end

  assign valid_o    = v3_q;
  assign res_o      = r3_q;
  assign screen_x_o = sx_q;
  assign screen_y_o = sy_q;
  assign sat_o      = sat3_q;

endmodule
`default_nettype wire

>>> hw/rtl/homogeneous_vertex_transform_top.sv
// Top level: configuration registers, matrix stages, divider chain, projection.
// Depends on hvt_pkg, hvt_if, hvt_mac, hvt_div_stage, hvt_proj.
//
//   Channel  Dir  Handshake        Content
//   in_s     in   valid / ready    vertex in_x, in_y, in_z, in_w
//   out_s    out  valid / ready    out_x..out_w, screen_x, screen_y, saturated
//   cfg      in   cfg_we_i         register cfg_index_i <= cfg_data_i
//
// One vertex per clock while the output is not stalled; 3 multiply/sum, 16 divider
// and 3 clip/projection/screen stages. The 16-step restoring divider sets the depth.
// Reset clears all valid bits and loads identity matrix, no divide, zero
// oblique factors and center. A stalled output freezes the whole pipe in place.
`timescale 1ns / 1ps
`default_nettype none
module homogeneous_vertex_transform_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  hvt_in_if.sink                            in_s,
  hvt_out_if.source                         out_s,
  input  logic                              cfg_we_i,
  input  logic [hvt_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [hvt_pkg::CFG_DAT_W-1:0]     cfg_data_i
);
  import hvt_pkg::*;

  localparam int DIV_STEPS = COORD_W;

  logic [3:0][MAT_W-1:0]    mat_q;
  logic                     div_en_q;
  logic [2*COORD_W-1:0]     obl_q;
  logic [2*COORD_W-1:0]     ctr_q;
  logic                     adv;
  logic                     mac_valid;
  div_t                     mac_div;
  logic                     dv [DIV_STEPS+1];
  div_t                     dd [DIV_STEPS+1];
  logic [3:0][COORD_W-1:0]  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q[0] <= MAT_W'(1) << FRAC_BITS;
      mat_q[1] <= MAT_W'(1) << (FRAC_BITS + COEF_W);
      mat_q[2] <= MAT_W'(1) << (FRAC_BITS + 2*COEF_W);
      mat_q[3] <= MAT_W'(1) << (FRAC_BITS + 3*COEF_W);
      div_en_q <= 1'b0;
      obl_q    <= '0;
      ctr_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MAT_X:   mat_q[0] <= cfg_data_i[MAT_W-1:0];
        CFG_MAT_Y:   mat_q[1] <= cfg_data_i[MAT_W-1:0];
        CFG_MAT_Z:   mat_q[2] <= cfg_data_i[MAT_W-1:0];
        CFG_MAT_W:   mat_q[3] <= cfg_data_i[MAT_W-1:0];
        CFG_DIV_EN:  div_en_q <= cfg_data_i[0];
        CFG_OBLIQUE: obl_q    <= cfg_data_i[2*COORD_W-1:0];
        CFG_CENTER:  ctr_q    <= cfg_data_i[2*COORD_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv        = !out_s.valid || out_s.ready;
  assign in_s.ready = adv;

  hvt_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (in_s.valid),
    .vtx_i    ({in_s.in_w, in_s.in_z, in_s.in_y, in_s.in_x}),
    .mat_i    (mat_q),
    .div_en_i (div_en_q),
    .valid_o  (mac_valid),
    .div_o    (mac_div)
  );

  assign dv[0] = mac_valid;
  assign dd[0] = mac_div;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    hvt_div_stage u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (dv[i]),
      .div_i   (dd[i]),
      .valid_o (dv[i+1]),
      .div_o   (dd[i+1])
    );
  end

  hvt_proj u_proj (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .valid_i    (dv[DIV_STEPS]),
    .div_i      (dd[DIV_STEPS]),
    .obl_i      (obl_q),
    .ctr_i      (ctr_q),
    .valid_o    (out_s.valid),
    .res_o      (res),
    .screen_x_o (out_s.screen_x),
    .screen_y_o (out_s.screen_y),
    .sat_o      (out_s.saturated)
  );

  assign out_s.out_x = res[0];
  assign out_s.out_y = res[1];
  assign out_s.out_z = res[2];
  assign out_s.out_w = res[3];

endmodule
`default_nettype wire

>>> hw/rtl/hvt_checker.sv
// Port-level checker for the vertex transform, bound to the top level.
// Depends on hvt_pkg and homogeneous_vertex_transform_top.
`timescale 1ns / 1ps
`default_nettype none
module hvt_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [hvt_pkg::COORD_W-1:0]  screen_x_i,
  input logic [hvt_pkg::COORD_W-1:0]  out_x_i,
  input logic                         sat_i
);
  import hvt_pkg::*;

  // input side is free whenever the output register is free or draining
  a_ready_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready does not follow output register state");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_x_i) && $stable(screen_x_i) && $stable(sat_i))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result shown during reset");

  // a stall holds everything, so nothing new can be taken in either
  a_no_take_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !(in_valid_i && in_ready_i))
    else $error("transfer accepted while pipeline stalled");

endmodule

bind homogeneous_vertex_transform_top hvt_checker u_hvt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_s.valid),
  .in_ready_i  (in_s.ready),
  .out_valid_i (out_s.valid),
  .out_ready_i (out_s.ready),
  .screen_x_i  (out_s.screen_x),
  .out_x_i     (out_s.out_x),
  .sat_i       (out_s.saturated)
);
`default_nettype wire

>>> tb/tb.sv
// Self-checking bench for homogeneous_vertex_transform_top: random and directed vertices
// against an in-bench transform predictor. Depends on hvt_pkg, hvt_if and the RTL.
`timescale 1ns / 1ps
module tb;
  import hvt_pkg::*;

  typedef struct packed {
    logic [15:0] x, y, z, w;
  } vtx_t;

  typedef struct packed {
    logic [15:0] ox, oy, oz, ow, sx, sy;
    logic        sat;
  } xf_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;

  hvt_in_if  in_s();
  hvt_out_if out_s();

  homogeneous_vertex_transform_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_s(in_s), .out_s(out_s),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  // predictor's copy of the registers
  logic [63:0] mat_col [4];
  logic        div_on;
  logic [31:0] obl_f, ctr_c;

  vtx_t vtx_pending [$];
  xf_t  xf_expected [$];
  int   err_cnt, idle_cycles;
  bit   no_idle;
  bit   in_acc;
  int   src_gap, snk_gap;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clip16(longint v, ref bit sat);
    if (v > 32767) begin sat = 1; return 32767; end
    if (v < -32768) begin sat = 1; return -32768; end
    return v;
  endfunction

  function automatic longint fshr(longint v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic xf_t transform(vtx_t v);
    longint vin [4], s [4], r [4];
    longint fx, fy, cx, cy, px, py;
    bit sat;
    xf_t o;
    sat = 0;
    vin[0] = $signed(v.x); vin[1] = $signed(v.y);
    vin[2] = $signed(v.z); vin[3] = $signed(v.w);
    for (int j = 0; j < 4; j++) begin
      s[j] = 0;
      for (int k = 0; k < 4; k++)
        s[j] += vin[k] * longint'($signed(mat_col[j][16*k +: 16]));
    end
    if (div_on && s[3] != 0) begin
      for (int j = 0; j < 3; j++) r[j] = s[j] / s[3];  // truncates toward zero
      r[3] = 1;
    end else begin
      for (int j = 0; j < 4; j++) r[j] = fshr(s[j]);
    end
    for (int j = 0; j < 4; j++) r[j] = clip16(r[j], sat);
    fx = $signed(obl_f[15:0]);  fy = $signed(obl_f[31:16]);
    cx = $signed(ctr_c[15:0]);  cy = $signed(ctr_c[31:16]);
    px = r[0] + fshr(r[2] * fx);
    py = r[1] + fshr(r[2] * fy);
    o.ox = r[0][15:0]; o.oy = r[1][15:0]; o.oz = r[2][15:0]; o.ow = r[3][15:0];
    o.sx = 16'(clip16(cx + px, sat));
    o.sy = 16'(clip16(cy - py, sat));
    o.sat = sat;
    return o;
  endfunction

  // driver; a shown vertex stays put until its transfer
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_acc) void'(vtx_pending.pop_front());
      if (in_s.valid && !in_acc) begin
        in_s.valid <= 1'b1;
      end else if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        in_s.valid <= 1'b0;
      end else if (vtx_pending.size() > 0) begin
        if (!no_idle && $urandom_range(0, 19) == 0) begin
          src_gap <= $urandom_range(1, 14);
          in_s.valid <= 1'b0;
        end else begin
          in_s.valid <= 1'b1;
          {in_s.in_x, in_s.in_y, in_s.in_z, in_s.in_w} <= vtx_pending[0];
        end
      end else begin
        in_s.valid <= 1'b0;
      end
      if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        out_s.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 19) == 0) begin
        snk_gap <= $urandom_range(1, 14);
        out_s.ready <= 1'b0;
      end else begin
        out_s.ready <= 1'b1;
      end
    end
  end

  // monitor: predict on input transfer, compare on output transfer
  always @(posedge clk_i) begin
    xf_t got, exp_xf;
    if (rst_ni) begin
      in_acc <= in_s.valid && in_s.ready;
      if ((in_s.valid && in_s.ready) || (out_s.valid && out_s.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (in_s.valid && in_s.ready) begin
        xf_expected.push_back(transform({in_s.in_x, in_s.in_y, in_s.in_z, in_s.in_w}));
      end
      if (out_s.valid && out_s.ready) begin
        got = {out_s.out_x, out_s.out_y, out_s.out_z, out_s.out_w,
               out_s.screen_x, out_s.screen_y, out_s.saturated};
        if (xf_expected.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected transfer: %h", got);
        end else begin
          exp_xf = xf_expected.pop_front();
          if (got !== exp_xf) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch exp x%h y%h z%h w%h sx%h sy%h s%b / got x%h y%h z%h w%h sx%h sy%h s%b",
                       exp_xf.ox, exp_xf.oy, exp_xf.oz, exp_xf.ow, exp_xf.sx, exp_xf.sy,
                       exp_xf.sat, got.ox, got.oy, got.oz, got.ow, got.sx, got.sy, got.sat);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles > 2000) begin
      $display("[homogeneous_vertex_transform_top] ERROR");
      $finish;
    end
  end

  task automatic cfg_write(cfg_idx_e idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_index_i = idx; cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_MAT_X:   mat_col[0] = val;
      CFG_MAT_Y:   mat_col[1] = val;
      CFG_MAT_Z:   mat_col[2] = val;
      CFG_MAT_W:   mat_col[3] = val;
      CFG_DIV_EN:  div_on = val[0];
      CFG_OBLIQUE: obl_f = val[31:0];
      CFG_CENTER:  ctr_c = val[31:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (vtx_pending.size() > 0 || xf_expected.size() > 0 || in_s.valid)
      @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rnd_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 64) - 32);
      default: return 16'($urandom_range(0, 4096) - 2048);
    endcase
  endfunction

  function automatic logic [63:0] rnd_mat(int mode);
    logic [63:0] m;
    for (int k = 0; k < 4; k++)
      m[16*k +: 16] = (mode == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024) - 512);
    return m;
  endfunction

  task automatic push_random(int n, int mode);
    vtx_t v;
    repeat (n) begin
      v.x = rnd_coord(mode); v.y = rnd_coord(mode); v.z = rnd_coord(mode);
      // mostly w near one so divides stay meaningful
      v.w = ($urandom_range(0, 3) == 0) ? rnd_coord(0) : 16'($urandom_range(0, 8) - 2);
      vtx_pending.push_back(v);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    in_s.valid = 1'b0; in_s.in_x = '0; in_s.in_y = '0; in_s.in_z = '0; in_s.in_w = '0;
    out_s.ready = 1'b0;
    mat_col[0] = 64'h100; mat_col[1] = 64'h1000000;
    mat_col[2] = 64'h10000000000; mat_col[3] = 64'h100000000000000;
    div_on = 0; obl_f = '0; ctr_c = '0;
    err_cnt = 0; idle_cycles = 0; no_idle = 0; src_gap = 0; snk_gap = 0; in_acc = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: identity extremes under reset settings
    vtx_pending.push_back({16'h7fff, 16'h8000, 16'h0000, 16'h0001});
    vtx_pending.push_back({16'h8000, 16'h7fff, 16'hffff, 16'h0000});
    vtx_pending.push_back({16'h0001, 16'hffff, 16'h7fff, 16'h8000});
    drain();
    // max-gain x and y rows: saturation cases
    cfg_write(CFG_MAT_X, 64'h7fff_7fff_7fff_7fff);
    cfg_write(CFG_MAT_Y, 64'h8000_8000_8000_8000);
    cfg_write(CFG_MAT_Z, 64'h0100_0000_0000_8000);
    cfg_write(CFG_OBLIQUE, 64'h7fff_8000);
    cfg_write(CFG_CENTER, 64'h8000_7fff);
    vtx_pending.push_back({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
    vtx_pending.push_back({16'h8000, 16'h8000, 16'h8000, 16'h8000});
    vtx_pending.push_back({16'h0003, 16'hfffd, 16'h0010, 16'h0001});
    drain();
    // divide: zero weight, tiny weight, negative quotients
    cfg_write(CFG_DIV_EN, 64'h1);
    cfg_write(CFG_MAT_X, 64'h0000_0000_0000_0100);
    cfg_write(CFG_MAT_Y, 64'h0000_0000_0100_0000);
    cfg_write(CFG_MAT_Z, 64'h0000_0100_0000_0000);
    cfg_write(CFG_MAT_W, 64'h0100_0000_0000_0000);
    cfg_write(CFG_OBLIQUE, 64'h0080_00dd);
    cfg_write(CFG_CENTER, 64'h00f0_0140);
    vtx_pending.push_back({16'h0064, 16'hff9c, 16'h0007, 16'h0000});
    vtx_pending.push_back({16'h7fff, 16'h8000, 16'h0001, 16'h0001});
    vtx_pending.push_back({16'hfff9, 16'h0007, 16'hfff9, 16'h0002});
    vtx_pending.push_back({16'h8000, 16'h0005, 16'h7fff, 16'hffff});
    vtx_pending.push_back({16'h0007, 16'hfff9, 16'h0003, 16'hfffe});
    drain();
    cfg_write(CFG_MAT_W, 64'h0000_0000_0000_0000);
    vtx_pending.push_back({16'h1234, 16'h4321, 16'h0100, 16'h0001});
    drain();

    // random phases
    for (int ph = 0; ph < 16; ph++) begin
      cfg_write(CFG_MAT_X, rnd_mat(ph % 2));
      cfg_write(CFG_MAT_Y, rnd_mat(ph % 2));
      cfg_write(CFG_MAT_Z, rnd_mat(ph % 2));
      cfg_write(CFG_MAT_W, rnd_mat(ph % 3 == 0 ? 0 : 1));
      cfg_write(CFG_DIV_EN, 64'($urandom_range(0, 1)));
      cfg_write(CFG_OBLIQUE, 64'($urandom));
      cfg_write(CFG_CENTER, (ph % 4 == 0) ? 64'($urandom) : 64'h00f0_0140);
      if (ph == 15) no_idle = 1;
      push_random(105, ph % 3);
      drain();
    end

    if (err_cnt == 0) begin
      $display("[homogeneous_vertex_transform_top] OK");
    end else begin
      $display("[homogeneous_vertex_transform_top] ERROR");
    end
    $finish;
  end
endmodule
